[rtl/rmfw_pkg.sv]
// ============================================================================
// rmfw_pkg - recursive mutex with FIFO waiters: shared types and constants
// Field widths, request mode codes and result status codes.
// ============================================================================
package rmfw_pkg;

  localparam int TID_W      = 4;   // thread identifier
  localparam int STATUS_W   = 4;   // result status code
  localparam int DEPTH_W    = 8;   // reported repeat count
  localparam int WCOUNT_W   = 5;   // reported waiter count
  localparam int NUM_TIDS   = 1 << TID_W;

  localparam int MAX_THREADS_DEF = 16;
  localparam int MAX_REPEAT_DEF  = 255;

  // request mode
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOT_FREE        = 4'd0,
    ST_NESTED          = 4'd1,
    ST_QUEUED          = 4'd2,
    ST_UNNEST          = 4'd3,
    ST_FREED           = 4'd4,
    ST_HANDED          = 4'd5,
    ST_NOT_HOLDER      = 4'd6,
    ST_ALREADY_WAITING = 4'd7,
    ST_COUNT_FULL      = 4'd8
  } status_t;

endpackage

[rtl/rmfw_if.sv]
// ============================================================================
// rmfw_req_if / rmfw_rsp_if - valid/ready channels of the mutex block
// Request channel carries mode and thread id; response carries lock state.
// ============================================================================
interface rmfw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [rmfw_pkg::TID_W-1:0]    thread_id;

  modport source (output valid, output mode, output thread_id, input ready);
  modport sink   (input valid, input mode, input thread_id, output ready);
endinterface

interface rmfw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rmfw_pkg::STATUS_W-1:0]  status;
  logic                           holder_valid;
  logic [rmfw_pkg::TID_W-1:0]     holder_now;
  logic [rmfw_pkg::DEPTH_W-1:0]   hold_depth;
  logic [rmfw_pkg::WCOUNT_W-1:0]  waiting_count;

  modport source (output valid, output status, output holder_valid, output holder_now,
                  output hold_depth, output waiting_count, input ready);
  modport sink   (input valid, input status, input holder_valid, input holder_now,
                  input hold_depth, input waiting_count, output ready);
endinterface

[rtl/recursive_mutex_fifo_waiters.sv]
// ============================================================================
// recursive_mutex_fifo_waiters - recursive lock with a FIFO of waiting threads
// Acquire/release requests update owner, repeat count and wait queue; every
// request returns one response with the lock state after the update.
// ============================================================================
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  ---------------------------------------
//  in_req    in   valid/ready         mode, thread_id
//  out_rsp   out  valid/ready         status, holder_valid, holder_now,
//                                     hold_depth, waiting_count
//
//  - One request per cycle while out_rsp does not stall; the response appears the cycle after the transfer.
//  - Latency and rate are set by one read-modify-write of the lock state plus
//    the registered read of the queue head entry, which is prefetched.
//  - in_req.ready is low only while a response is held because out_rsp stalls.
//  - rst_n (synchronous, active low) frees the lock and empties the queue; the
//    queue storage itself is not cleared and needs no clearing pass.
//
module recursive_mutex_fifo_waiters #(
  parameter int MAX_THREADS = rmfw_pkg::MAX_THREADS_DEF,  // queue depth, 2..256
  parameter int MAX_REPEAT  = rmfw_pkg::MAX_REPEAT_DEF    // nesting limit, 1..65535
) (
  input  logic         clk,
  input  logic         rst_n,
  rmfw_req_if.sink     in_req,
  rmfw_rsp_if.source   out_rsp
);

  localparam int IW = $clog2(MAX_THREADS);       // queue pointer
  localparam int CW = $clog2(MAX_THREADS + 1);   // queue fill count
  localparam int RW = $clog2(MAX_REPEAT + 1);    // repeat count
  localparam int TW = rmfw_pkg::TID_W;

  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_THREADS - 1);
  localparam logic [CW-1:0] QUEUE_CAP = CW'(MAX_THREADS);
  localparam logic [RW-1:0] REP_CAP   = RW'(MAX_REPEAT);
  localparam logic [RW-1:0] REP_ONE   = RW'(1);

  // --------------------------------------------------------------------------
  // lock state
  // --------------------------------------------------------------------------
  logic                         held_r,  held_nxt;
  logic [TW-1:0]                owner_r, owner_nxt;
  logic [RW-1:0]                rep_r,   rep_nxt;
  logic [IW-1:0]                head_r,  head_nxt;
  logic [IW-1:0]                tail_r,  tail_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [rmfw_pkg::NUM_TIDS-1:0] wmask_r, wmask_nxt;

  // wait queue storage; head entry is kept prefetched in head_data_r
  logic [TW-1:0] wait_mem [MAX_THREADS];
  logic [TW-1:0] head_data_r;
  logic          q_we;

  // response register
  logic                          out_valid_r;
  rmfw_pkg::status_t             status_r, status_nxt;
  logic                          hv_r;
  logic [TW-1:0]                 hnow_r;
  logic [rmfw_pkg::DEPTH_W-1:0]  depth_r;
  logic [rmfw_pkg::WCOUNT_W-1:0] wcount_r;

  logic in_xfer;
  logic out_xfer;

  assign out_xfer     = out_valid_r && out_rsp.ready;
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign in_xfer      = in_req.valid && in_req.ready;

  // --------------------------------------------------------------------------
  // request decode and state update
  // --------------------------------------------------------------------------
  always_comb begin
    held_nxt   = held_r;
    owner_nxt  = owner_r;
    rep_nxt    = rep_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    wmask_nxt  = wmask_r;
    q_we       = 1'b0;
    status_nxt = rmfw_pkg::ST_NOT_HOLDER;

    if (in_xfer) begin
      if (in_req.mode == rmfw_pkg::MODE_ACQUIRE) begin
        if (!held_r) begin
          held_nxt   = 1'b1;
          owner_nxt  = in_req.thread_id;
          rep_nxt    = REP_ONE;
          status_nxt = rmfw_pkg::ST_GOT_FREE;
        end else if (owner_r == in_req.thread_id) begin
          if (rep_r >= REP_CAP) begin
            status_nxt = rmfw_pkg::ST_COUNT_FULL;
          end else begin
            rep_nxt    = rep_r + REP_ONE;
            status_nxt = rmfw_pkg::ST_NESTED;
          end
        end else if (wmask_r[in_req.thread_id]) begin
          status_nxt = rmfw_pkg::ST_ALREADY_WAITING;
        end else if (count_r >= QUEUE_CAP) begin
          // queue full
          status_nxt = rmfw_pkg::ST_COUNT_FULL;
        end else begin
          q_we       = 1'b1;
          tail_nxt   = (tail_r == LAST_SLOT) ? '0 : tail_r + IW'(1);
          count_nxt  = count_r + CW'(1);
          wmask_nxt[in_req.thread_id] = 1'b1;
          status_nxt = rmfw_pkg::ST_QUEUED;
        end
      end else begin
        if (!held_r || owner_r != in_req.thread_id) begin
          status_nxt = rmfw_pkg::ST_NOT_HOLDER;
        end else if (rep_r > REP_ONE) begin
          rep_nxt    = rep_r - REP_ONE;
          status_nxt = rmfw_pkg::ST_UNNEST;
        end else if (count_r == '0) begin
          held_nxt   = 1'b0;
          owner_nxt  = '0;
          rep_nxt    = '0;
          status_nxt = rmfw_pkg::ST_FREED;
        end else begin
          // hand the lock straight to the oldest waiter
          head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + IW'(1);
          count_nxt  = count_r - CW'(1);
          wmask_nxt[head_data_r] = 1'b0;
          owner_nxt  = head_data_r;
          rep_nxt    = REP_ONE;
          status_nxt = rmfw_pkg::ST_HANDED;
        end
      end
    end
  end

  // zero-extend then slice, so the reported fields work at any parameter value
  logic [RW+rmfw_pkg::DEPTH_W-1:0]  rep_ext;
  logic [CW+rmfw_pkg::WCOUNT_W-1:0] cnt_ext;
  assign rep_ext = {{rmfw_pkg::DEPTH_W{1'b0}}, rep_nxt};
  assign cnt_ext = {{rmfw_pkg::WCOUNT_W{1'b0}}, count_nxt};

  // --------------------------------------------------------------------------
  // state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      owner_r <= '0;
      rep_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      wmask_r <= '0;
    end else begin
      held_r  <= held_nxt;
      owner_r <= owner_nxt;
      rep_r   <= rep_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      wmask_r <= wmask_nxt;
    end
  end

  // queue memory: one write port at tail, one registered read at the next head;
  // a write landing on the next head is forwarded
  always_ff @(posedge clk) begin
    if (q_we) begin
      wait_mem[tail_r] <= in_req.thread_id;
    end
    if (q_we && tail_r == head_nxt) begin
      head_data_r <= in_req.thread_id;
    end else begin
      head_data_r <= wait_mem[head_nxt];
    end
  end

  // --------------------------------------------------------------------------
  // response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      hv_r     <= held_nxt;
      hnow_r   <= held_nxt ? owner_nxt : '0;
      depth_r  <= held_nxt ? rep_ext[rmfw_pkg::DEPTH_W-1:0] : '0;
      wcount_r <= cnt_ext[rmfw_pkg::WCOUNT_W-1:0];
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.holder_valid  = hv_r;
  assign out_rsp.holder_now    = hnow_r;
  assign out_rsp.hold_depth    = depth_r;
  assign out_rsp.waiting_count = wcount_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // fill count tracks the set of waiting threads
  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(wmask_r) == int'(count_r))
    else $error("queue count disagrees with waiting mask");

  // a free lock never has waiters (release hands off directly)
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> count_r == '0)
    else $error("free lock with non-empty queue");

  // a held lock has a nonzero repeat count
  a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> rep_r != '0)
    else $error("held lock with zero repeat count");

  // the holder is never also waiting
  a_owner_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> !wmask_r[owner_r])
    else $error("lock holder is marked as waiting");

  // a handoff leaves the receiver holding at depth one
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && status_nxt == rmfw_pkg::ST_HANDED) |=> (held_r && rep_r == REP_ONE))
    else $error("handoff did not grant the lock at depth one");

endmodule
